@@ hw/rtl/pldl_pkg.sv @@
`timescale 1ns / 1ps
// pldl_pkg: shared constants, sequencer states and divider handshake types
// for the phase locked delay line; no dependencies

package pldl_pkg;

  localparam int LEN     = 1024;
  localparam int AW      = 10;
  localparam int HALF    = LEN / 2;
  localparam int MAX_RUN = 64;
  localparam int RUN_W   = 7;
  localparam int SUM_W   = 32;
  localparam int CNT_W   = 8;
  localparam int SMP_W   = 24;
  localparam int GAP_W   = 10;
  localparam int TOL_W   = 9;
  localparam int SAT_W   = 23;
  localparam int CFG_W   = 23;
  localparam int IDX_W   = 2;
  localparam int ENTRY_W = SUM_W + CNT_W;
  localparam int DVD_W   = 44;
  localparam int DVS_W   = AW;
  localparam int STEP_W  = $clog2(DVD_W + 1);

  localparam logic [IDX_W-1:0] REG_GAP = 2'd0;
  localparam logic [IDX_W-1:0] REG_TOL = 2'd1;
  localparam logic [IDX_W-1:0] REG_SAT = 2'd2;

  localparam logic [SAT_W-1:0] SAT_RESET = 23'd65536;
  localparam logic [CNT_W-1:0] CNT_FULL  = 8'd255;

  typedef enum logic [13:0] {
    S_CLEAR  = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_WR_CHK = 14'b00000000000100,
    S_SETUP  = 14'b00000000001000,
    S_TOP    = 14'b00000000010000,
    S_AV_CHK = 14'b00000000100000,
    S_AV_PRD = 14'b00000001000000,
    S_DIV_AV = 14'b00000010000000,
    S_MUL1   = 14'b00000100000000,
    S_MUL2   = 14'b00001000000000,
    S_BLS    = 14'b00010000000000,
    S_DIV_BL = 14'b00100000000000,
    S_EMIT   = 14'b01000000000000,
    S_SPARE  = 14'b10000000000000
  } state_t;

  typedef struct packed {
    logic                    start;
    logic signed [DVD_W-1:0] dividend;
    logic [DVS_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ hw/rtl/pldl_ram.sv @@
`timescale 1ns / 1ps
// pldl_ram: generic single write port, single read port ram with registered read
// no dependencies

module pldl_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/pldl_div.sv @@
`timescale 1ns / 1ps
// pldl_div: signed by unsigned restoring divider, one quotient bit per cycle,
// truncates toward zero; depends on pldl_pkg

module pldl_div (
  input  logic               clk,
  input  logic               rst,
  input  pldl_pkg::div_req_t req,
  output pldl_pkg::div_rsp_t rsp
);

  logic                                busy;
  logic                                done;
  logic                                neg;
  logic [pldl_pkg::STEP_W-1:0]         step;
  logic [pldl_pkg::DVD_W-1:0]          quo;
  logic [pldl_pkg::DVS_W:0]            rem;
  logic [pldl_pkg::DVS_W-1:0]          dvs;
  logic [pldl_pkg::DVS_W:0]            rem_sh;
  logic                                fits;
  logic [pldl_pkg::DVD_W-1:0]          quo_signed;

  assign rem_sh = {rem[pldl_pkg::DVS_W-1:0], quo[pldl_pkg::DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= pldl_pkg::STEP_W'(pldl_pkg::DVD_W);
        neg  <= req.dividend[pldl_pkg::DVD_W-1];
        quo  <= req.dividend[pldl_pkg::DVD_W-1] ? -req.dividend : req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (busy) begin
        rem  <= fits ? rem_sh - {1'b0, dvs} : rem_sh;
        quo  <= {quo[pldl_pkg::DVD_W-2:0], fits};
        step <= step - 1'b1;
        if (step == pldl_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo_signed   = neg ? -quo : quo;
  assign rsp.done     = done;
  assign rsp.quotient = quo_signed[pldl_pkg::SUM_W-1:0];

endmodule

@@ hw/rtl/phase_locked_delay_line.sv @@
`timescale 1ns / 1ps
// Averaging delay line for one audio channel. Per-slot sum and count live in one
// ram of LEN entries, cleared by a sweep after reset during which no beat is
// taken. A write beat reads the slot in the accept cycle and writes it back in
// the next one. A read beat passes through accept, setup and wrap-up, plus an
// averaging divide of the far slot if the read pointer is pulled in (an empty far
// slot borrows from its predecessor), plus per output beat an averaging divide (an
// empty slot borrows from its predecessor, or from the far slot while blending)
// and a blend divide while blending, plus any time the output is stalled; the
// shared divider yields one quotient bit per cycle over a 44 bit dividend and
// serves both the slot averages and the blend.
// Depends on pldl_pkg, pldl_ram and pldl_div.

module phase_locked_delay_line (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [pldl_pkg::IDX_W-1:0]        cfg_index,
  input  logic [pldl_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              op,
  input  logic [pldl_pkg::AW-1:0]           position,
  input  logic signed [pldl_pkg::SMP_W-1:0] sample_in,
  input  logic [pldl_pkg::RUN_W-1:0]        sample_count,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pldl_pkg::SMP_W-1:0] sample_out,
  output logic                              last
);

  localparam int AW    = pldl_pkg::AW;
  localparam int SUM_W = pldl_pkg::SUM_W;
  localparam int CNT_W = pldl_pkg::CNT_W;
  localparam int DVD_W = pldl_pkg::DVD_W;

  pldl_pkg::state_t state;

  logic [pldl_pkg::GAP_W-1:0] gap_offset;
  logic [pldl_pkg::TOL_W-1:0] tolerance;
  logic [pldl_pkg::SAT_W-1:0] saturation_limit;

  logic [AW-1:0]                    clr_addr;
  logic [AW-1:0]                    read_pointer;
  logic [AW-1:0]                    pos;
  logic signed [pldl_pkg::SMP_W-1:0] smp;
  logic                             is_read;
  logic [pldl_pkg::RUN_W-1:0]       run_left;
  logic [AW-1:0]                    cur;
  logic [AW-1:0]                    far;
  logic [AW-1:0]                    dif;
  logic [AW-1:0]                    num;
  logic [AW-1:0]                    av_addr;
  logic                             in_loop;
  logic signed [SUM_W-1:0]          far_sum;
  logic signed [SUM_W-1:0]          val;
  logic signed [DVD_W-1:0]          p1;
  logic signed [DVD_W-1:0]          p2;

  // ram ports
  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [pldl_pkg::ENTRY_W-1:0]    ram_wdata;
  logic                            ram_re;
  logic [AW-1:0]                   ram_raddr;
  logic [pldl_pkg::ENTRY_W-1:0]    ram_rdata;
  logic signed [SUM_W-1:0]         rd_sum;
  logic [CNT_W-1:0]                rd_cnt;

  pldl_pkg::div_req_t div_req;
  pldl_pkg::div_rsp_t div_rsp;

  logic in_acc;
  logic out_free;

  // arc decisions
  logic [AW-1:0] target;
  logic [AW-1:0] tol_w;
  logic [AW-1:0] hi;
  logic [AW-1:0] lo;
  logic [AW-1:0] d_rh;
  logic [AW-1:0] d_lr;
  logic [AW:0]   arc_a;
  logic [AW:0]   arc_b;
  logic          near_a;
  logic          near_b;

  logic signed [SUM_W-1:0] neg_sat;
  logic signed [SUM_W-1:0] pos_sat;
  logic signed [SUM_W-1:0] clamped;
  logic [CNT_W-1:0]        prd_cnt;
  logic [SUM_W-1:0]        wr_sum;
  logic [AW-1:0]           dif_eff;

  assign rd_sum = ram_rdata[pldl_pkg::ENTRY_W-1:CNT_W];
  assign rd_cnt = ram_rdata[CNT_W-1:0];

  assign in_stall = state != pldl_pkg::S_IDLE;
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign target = pos + gap_offset;
  assign tol_w  = {{(AW - pldl_pkg::TOL_W){1'b0}}, tolerance};
  assign hi     = target + tol_w;
  assign lo     = target - tol_w;
  assign d_rh   = read_pointer - hi;
  assign d_lr   = lo - read_pointer;
  assign arc_a  = {1'b0, tol_w} + {1'b0, d_rh};
  assign arc_b  = {1'b0, d_lr} + {1'b0, tol_w};
  assign near_a = arc_a < (AW + 1)'(pldl_pkg::HALF);
  assign near_b = arc_b < (AW + 1)'(pldl_pkg::HALF);

  assign pos_sat = {{(SUM_W - pldl_pkg::SAT_W){1'b0}}, saturation_limit};
  assign neg_sat = -pos_sat;
  assign clamped = (val < neg_sat) ? neg_sat : ((val > pos_sat) ? pos_sat : val);

  assign prd_cnt = (rd_cnt == '0) ? CNT_W'(1) : rd_cnt;
  assign wr_sum  = ((rd_cnt == '0) ? '0 : rd_sum)
                   + {{(SUM_W - pldl_pkg::SMP_W){smp[pldl_pkg::SMP_W-1]}}, smp};
  assign dif_eff = (dif != '0 && cur == far) ? '0 : dif;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_offset       <= '0;
      tolerance        <= '0;
      saturation_limit <= pldl_pkg::SAT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pldl_pkg::REG_GAP: gap_offset       <= cfg_data[pldl_pkg::GAP_W-1:0];
        pldl_pkg::REG_TOL: tolerance        <= cfg_data[pldl_pkg::TOL_W-1:0];
        pldl_pkg::REG_SAT: saturation_limit <= cfg_data[pldl_pkg::SAT_W-1:0];
        default: ;
      endcase
    end
  end

  // ram and divider request decode
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = av_addr;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = av_addr;
    div_req   = '0;
    unique case (state)
      pldl_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      pldl_pkg::S_IDLE: begin
        ram_re    = in_acc && !op;
        ram_raddr = position;
      end
      pldl_pkg::S_WR_CHK: begin
        ram_we    = rd_cnt != pldl_pkg::CNT_FULL;
        ram_waddr = pos;
        ram_wdata = {wr_sum, rd_cnt + 1'b1};
      end
      pldl_pkg::S_SETUP: begin
        ram_re    = near_a || near_b;
        ram_raddr = near_a ? read_pointer : target;
      end
      pldl_pkg::S_TOP: begin
        ram_re    = run_left != '0;
        ram_raddr = cur;
      end
      pldl_pkg::S_AV_CHK: begin
        if (in_loop && dif != '0 && rd_cnt == '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = DVD_W'(far_sum);
          div_req.divisor  = AW'(1);
        end else if (rd_cnt != '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = DVD_W'(rd_sum);
          div_req.divisor  = {{(AW - CNT_W){1'b0}}, rd_cnt};
        end else begin
          ram_re    = 1'b1;
          ram_raddr = av_addr - 1'b1;
        end
      end
      pldl_pkg::S_AV_PRD: begin
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'(rd_sum);
        div_req.divisor  = {{(AW - CNT_W){1'b0}}, prd_cnt};
      end
      pldl_pkg::S_DIV_AV: begin
        ram_we    = div_rsp.done && !in_loop;
        ram_wdata = {div_rsp.quotient, CNT_W'(1)};
      end
      pldl_pkg::S_BLS: begin
        div_req.start    = 1'b1;
        div_req.dividend = p1 + p2;
        div_req.divisor  = dif;
      end
      pldl_pkg::S_EMIT: begin
        ram_we    = out_free;
        ram_waddr = cur;
        ram_wdata = {val, CNT_W'(0)};
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pldl_pkg::S_CLEAR;
      clr_addr     <= '0;
      read_pointer <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        pldl_pkg::S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(pldl_pkg::LEN - 1)) begin
            state <= pldl_pkg::S_IDLE;
          end
        end
        pldl_pkg::S_IDLE: begin
          if (in_acc) begin
            pos      <= position;
            smp      <= sample_in;
            is_read  <= op;
            run_left <= (sample_count > pldl_pkg::RUN_W'(pldl_pkg::MAX_RUN))
                        ? pldl_pkg::RUN_W'(pldl_pkg::MAX_RUN) : sample_count;
            state    <= op ? pldl_pkg::S_SETUP : pldl_pkg::S_WR_CHK;
          end
        end
        pldl_pkg::S_WR_CHK: begin
          state <= pldl_pkg::S_IDLE;
        end
        pldl_pkg::S_SETUP: begin
          num     <= '0;
          in_loop <= 1'b0;
          if (near_a) begin
            // read pointer ahead of the window: blend from target up to it
            dif     <= read_pointer - target;
            cur     <= target;
            far     <= read_pointer;
            av_addr <= read_pointer;
            state   <= pldl_pkg::S_AV_CHK;
          end else if (near_b) begin
            dif     <= target - read_pointer;
            cur     <= read_pointer;
            far     <= target;
            av_addr <= target;
            state   <= pldl_pkg::S_AV_CHK;
          end else begin
            dif   <= '0;
            cur   <= read_pointer;
            far   <= read_pointer;
            state <= pldl_pkg::S_TOP;
          end
        end
        pldl_pkg::S_TOP: begin
          if (run_left == '0) begin
            read_pointer <= cur;
            state        <= pldl_pkg::S_IDLE;
          end else begin
            dif     <= dif_eff;
            in_loop <= 1'b1;
            av_addr <= cur;
            state   <= pldl_pkg::S_AV_CHK;
          end
        end
        pldl_pkg::S_AV_CHK: begin
          if ((in_loop && dif != '0 && rd_cnt == '0) || rd_cnt != '0) begin
            state <= pldl_pkg::S_DIV_AV;
          end else begin
            state <= pldl_pkg::S_AV_PRD;
          end
        end
        pldl_pkg::S_AV_PRD: begin
          state <= pldl_pkg::S_DIV_AV;
        end
        pldl_pkg::S_DIV_AV: begin
          if (div_rsp.done) begin
            if (!in_loop) begin
              far_sum <= div_rsp.quotient;
              state   <= pldl_pkg::S_TOP;
            end else begin
              val   <= div_rsp.quotient;
              state <= (dif != '0) ? pldl_pkg::S_MUL1 : pldl_pkg::S_EMIT;
            end
          end
        end
        pldl_pkg::S_MUL1: begin
          p1    <= $signed({1'b0, num}) * val;
          state <= pldl_pkg::S_MUL2;
        end
        pldl_pkg::S_MUL2: begin
          p2    <= $signed({1'b0, dif - num}) * far_sum;
          state <= pldl_pkg::S_BLS;
        end
        pldl_pkg::S_BLS: begin
          state <= pldl_pkg::S_DIV_BL;
        end
        pldl_pkg::S_DIV_BL: begin
          if (div_rsp.done) begin
            val   <= div_rsp.quotient;
            num   <= num + 1'b1;
            state <= pldl_pkg::S_EMIT;
          end
        end
        pldl_pkg::S_EMIT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            sample_out <= clamped[pldl_pkg::SMP_W-1:0];
            last       <= run_left == pldl_pkg::RUN_W'(1);
            cur        <= cur + 1'b1;
            run_left   <= run_left - 1'b1;
            state      <= pldl_pkg::S_TOP;
          end
        end
        default: begin
          state <= pldl_pkg::S_IDLE;
        end
      endcase
    end
  end

  pldl_ram #(
    .WIDTH(pldl_pkg::ENTRY_W),
    .DEPTH(pldl_pkg::LEN)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  pldl_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  // divider results only show up while the sequencer waits for them
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == pldl_pkg::S_DIV_AV || state == pldl_pkg::S_DIV_BL))
    else $error("divider result outside a wait state");

  // blend weight stays below the arc length
  a_blend_weight: assert property (@(posedge clk) disable iff (rst)
    state == pldl_pkg::S_MUL1 |-> (num < dif && is_read))
    else $error("blend weight out of range");

  // a blended slot never sits on the far end of the arc
  a_blend_not_far: assert property (@(posedge clk) disable iff (rst)
    (state == pldl_pkg::S_AV_CHK && in_loop && dif != '0) |-> cur != far)
    else $error("blending at the far slot");

  // a beat is only emitted while the run still has beats left
  a_emit_run: assert property (@(posedge clk) disable iff (rst)
    state == pldl_pkg::S_EMIT |-> run_left != '0)
    else $error("beat emitted past end of run");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// testbench for phase_locked_delay_line: directed and random write/read beats
// checked against an in-bench model of the slot ram, read pointer and blending;
// depends on pldl_pkg and the rtl of the delay line

module testbench;

  localparam int CYCLE_LIMIT = 10000000;
  localparam int SETTLE = 300;
  localparam int HOLD_CYCLES = 3000;

  typedef struct {
    logic signed [pldl_pkg::SMP_W-1:0] smp;
    logic                              lst;
  } beat_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_write;
  logic [pldl_pkg::IDX_W-1:0]        cfg_index;
  logic [pldl_pkg::CFG_W-1:0]        cfg_data;
  logic                              in_valid;
  logic                              in_stall;
  logic                              op;
  logic [pldl_pkg::AW-1:0]           position;
  logic signed [pldl_pkg::SMP_W-1:0] sample_in;
  logic [pldl_pkg::RUN_W-1:0]        sample_count;
  logic                              out_valid;
  logic                              out_stall;
  logic signed [pldl_pkg::SMP_W-1:0] sample_out;
  logic                              last;

  phase_locked_delay_line u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // model state
  int             slot_sum_m [pldl_pkg::LEN];
  byte unsigned   slot_cnt_m [pldl_pkg::LEN];
  int unsigned    rd_ptr_m;
  int unsigned    gap_m, tol_m, sat_m;

  beat_t          pending_samples[$];
  int             mismatches, reads_sent, writes_sent, beats_seen;
  int             cycles;
  int             stall_hold;
  int             hold_requests;
  int             hold_served;
  bit             quiet;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic int unsigned wrap_add(int unsigned a, int unsigned b);
    return (a + b % pldl_pkg::LEN) % pldl_pkg::LEN;
  endfunction

  function automatic int unsigned wrap_sub(int unsigned a, int unsigned b);
    return (a + pldl_pkg::LEN - b % pldl_pkg::LEN) % pldl_pkg::LEN;
  endfunction

  function automatic bit short_path(int unsigned a, int unsigned b, int unsigned c);
    return (wrap_sub(b, a) + wrap_sub(c, b)) * 2 < pldl_pkg::LEN;
  endfunction

  function automatic void reduce_slot(int unsigned s);
    int unsigned p;
    if (slot_cnt_m[s] == 0) begin
      p = wrap_sub(s, 1);
      slot_sum_m[s] = slot_sum_m[p];
      slot_cnt_m[s] = slot_cnt_m[p];
      if (slot_cnt_m[s] == 0) slot_cnt_m[s] = 1;
    end
    slot_sum_m[s] = slot_sum_m[s] / int'(slot_cnt_m[s]);
    slot_cnt_m[s] = 1;
  endfunction

  function automatic void accumulate(int unsigned pos,
                                     logic signed [pldl_pkg::SMP_W-1:0] smp);
    if (slot_cnt_m[pos] == pldl_pkg::CNT_FULL) return;
    if (slot_cnt_m[pos] == 0) slot_sum_m[pos] = 0;
    slot_sum_m[pos] += int'(smp);
    slot_cnt_m[pos]++;
  endfunction

  function automatic void predict_run(int unsigned pos, int unsigned cnt);
    int unsigned run, target, lo, hi, rp, cur, far_s;
    int          dif, num;
    longint      acc, v, sat;
    beat_t       b;
    run = (cnt > pldl_pkg::MAX_RUN) ? pldl_pkg::MAX_RUN : cnt;
    target = wrap_add(pos, gap_m);
    lo = wrap_sub(target, tol_m);
    hi = wrap_add(target, tol_m);
    rp = rd_ptr_m;
    num = 0;
    far_s = 0;
    if (short_path(target, hi, rp)) begin
      dif = wrap_sub(rp, target);
      cur = target;
      far_s = rp;
      reduce_slot(far_s);
    end else if (short_path(rp, lo, target)) begin
      dif = wrap_sub(target, rp);
      cur = rp;
      far_s = target;
      reduce_slot(far_s);
    end else begin
      dif = 0;
      cur = rp;
    end
    sat = longint'(sat_m);
    for (int unsigned k = 0; k < run; k++) begin
      if (dif != 0 && cur == far_s) dif = 0;
      if (dif != 0 && slot_cnt_m[cur] == 0) begin
        slot_sum_m[cur] = slot_sum_m[far_s];
        slot_cnt_m[cur] = slot_cnt_m[far_s];
      end
      reduce_slot(cur);
      if (dif != 0) begin
        acc = longint'(num) * longint'(slot_sum_m[cur])
            + longint'(dif - num) * longint'(slot_sum_m[far_s]);
        slot_sum_m[cur] = int'(acc / longint'(dif));
        num++;
      end
      v = longint'(slot_sum_m[cur]);
      if (v < -sat) v = -sat;
      else if (v > sat) v = sat;
      b.smp = v[pldl_pkg::SMP_W-1:0];
      b.lst = (k + 1 == run);
      pending_samples.push_back(b);
      slot_cnt_m[cur] = 0;
      cur = wrap_add(cur, 1);
    end
    rd_ptr_m = cur;
  endfunction

  // result side: check accepted beats, stall at random or for a requested hold
  always @(posedge clk) begin
    beat_t e;
    if (!rst && out_valid && !out_stall) begin
      beats_seen++;
      if (pending_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: sample %0d last %0b", sample_out, last);
      end else begin
        e = pending_samples.pop_front();
        if (e.smp !== sample_out || e.lst !== last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected sample %0d last %0b, got sample %0d last %0b",
                     e.smp, e.lst, sample_out, last);
        end
      end
    end
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      stall_hold <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (stall_hold > 0) begin
      out_stall <= 1'b1;
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 16);
    end
  end

  task automatic send_beat(bit w_op, int unsigned pos,
                           logic signed [pldl_pkg::SMP_W-1:0] smp, int unsigned cnt);
    while (!quiet && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= w_op;
    position <= pos[pldl_pkg::AW-1:0];
    sample_in <= smp;
    sample_count <= cnt[pldl_pkg::RUN_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (w_op == 1'b0) begin
      accumulate(pos % pldl_pkg::LEN, smp);
      writes_sent++;
    end else begin
      predict_run(pos % pldl_pkg::LEN, cnt);
      reads_sent++;
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [pldl_pkg::IDX_W-1:0] idx, int unsigned val);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[pldl_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      pldl_pkg::REG_GAP: gap_m = val & 32'h3FF;
      pldl_pkg::REG_TOL: tol_m = val & 32'h1FF;
      pldl_pkg::REG_SAT: sat_m = val & 32'h7FFFFF;
      default: ;
    endcase
  endtask

  task automatic test_reset_defaults();
    // reset config: gap 0, tolerance 0, clamp at 1.0; empty slots copy predecessor
    send_beat(1'b1, 0, '0, 3);
    send_beat(1'b0, 3, 24'sh7FFFFF, 0);
    send_beat(1'b0, 3, 24'sh000001, 0);
    send_beat(1'b0, 4, -24'sh800000, 0);
    send_beat(1'b1, 3, '0, 4);
  endtask

  task automatic test_directed();
    write_reg(pldl_pkg::REG_SAT, 23'h7FFFFF);
    write_reg(pldl_pkg::REG_GAP, 1023);
    write_reg(pldl_pkg::REG_TOL, 0);
    // wrap at the top of the ring, extremes of the sample
    send_beat(1'b0, 1022, 24'sh7FFFFF, 0);
    send_beat(1'b0, 1022, 24'sh7FFFFF, 0);
    send_beat(1'b0, 1023, -24'sh800000, 0);
    send_beat(1'b0, 0, -24'sh000003, 0);
    send_beat(1'b0, 0, 24'sh000002, 0);
    send_beat(1'b1, 1023, '0, 4);
    // zero run still touches the arc end; long run saturates to the maximum
    send_beat(1'b1, 500, '0, 0);
    send_beat(1'b1, 10, '0, 127);
    // pull from both sides with tolerance
    write_reg(pldl_pkg::REG_GAP, 5);
    write_reg(pldl_pkg::REG_TOL, 2);
    send_beat(1'b0, 80, 24'sh010000, 0);
    send_beat(1'b0, 85, -24'sh020000, 0);
    send_beat(1'b1, 70, '0, 6);
    send_beat(1'b0, 30, 24'sh123456, 0);
    send_beat(1'b1, 20, '0, 8);
    write_reg(pldl_pkg::REG_SAT, 0);
    send_beat(1'b1, 21, '0, 2);
    write_reg(pldl_pkg::REG_TOL, 511);
    send_beat(1'b1, 700, '0, 3);
  endtask

  task automatic test_full_slot();
    write_reg(pldl_pkg::REG_SAT, 23'h400000);
    write_reg(pldl_pkg::REG_TOL, 0);
    write_reg(pldl_pkg::REG_GAP, 0);
    quiet = 1'b1;
    for (int i = 0; i < 258; i++)
      send_beat(1'b0, 200, pldl_pkg::SMP_W'(24'sh7FFFFF - i), 0);
    quiet = 1'b0;
    send_beat(1'b1, 200, '0, 2);
  endtask

  task automatic test_backpressure();
    write_reg(pldl_pkg::REG_TOL, 1);
    hold_requests++;
    for (int i = 0; i < 6; i++) begin
      send_beat(1'b0, 300 + i, pldl_pkg::SMP_W'($urandom), 0);
      send_beat(1'b1, 300 + i, '0, 8);
    end
    settle();
  endtask

  task automatic test_random();
    int unsigned base, r, cnt;
    base = $urandom_range(pldl_pkg::LEN - 1);
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(pldl_pkg::REG_GAP, $urandom_range(20));
          write_reg(pldl_pkg::REG_TOL, $urandom_range(8));
          write_reg(pldl_pkg::REG_SAT, $urandom);
        end
        1: begin
          write_reg(pldl_pkg::REG_GAP, $urandom);
          write_reg(pldl_pkg::REG_TOL, $urandom);
        end
        2: begin
          write_reg(pldl_pkg::REG_GAP, 1023);
          write_reg(pldl_pkg::REG_TOL, 511);
          write_reg(pldl_pkg::REG_SAT, 23'h7FFFFF);
        end
        default: begin
          write_reg(pldl_pkg::REG_GAP, 0);
          write_reg(pldl_pkg::REG_TOL, 0);
          write_reg(pldl_pkg::REG_SAT, 0);
        end
      endcase
      quiet = (phase == 1);
      for (int i = 0; i < 10; i++) begin
        r = $urandom_range(99);
        if (r < 55) begin
          send_beat(1'b0, (base + gap_m + $urandom_range(12)) % pldl_pkg::LEN,
                    pldl_pkg::SMP_W'($urandom), 0);
        end else if (r < 60) begin
          send_beat(1'b0, $urandom, pldl_pkg::SMP_W'($urandom), 0);
        end else begin
          r = $urandom_range(99);
          if (r < 3) cnt = 0;
          else if (r < 7) cnt = $urandom_range(127, 64);
          else cnt = $urandom_range(8, 1);
          send_beat(1'b1, (r < 10) ? $urandom : base, '0, cnt);
          base = (base + $urandom_range(6)) % pldl_pkg::LEN;
        end
      end
      quiet = 1'b0;
    end
  endtask

  initial begin
    for (int i = 0; i < pldl_pkg::LEN; i++) begin
      slot_sum_m[i] = 0;
      slot_cnt_m[i] = 0;
    end
    rd_ptr_m = 0;
    gap_m = 0;
    tol_m = 0;
    sat_m = pldl_pkg::SAT_RESET;
    hold_requests = 0;
    cfg_write <= 1'b0;
    cfg_index <= pldl_pkg::REG_GAP;
    cfg_data <= '0;
    in_valid <= 1'b0;
    op <= 1'b0;
    position <= '0;
    sample_in <= '0;
    sample_count <= '0;
    out_stall <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_directed();
    test_full_slot();
    test_backpressure();
    test_random();
    settle();

    $display("covered %0d write beats and %0d read beats, %0d output beats checked",
             writes_sent, reads_sent, beats_seen);
    $display("config sweeps included gap, tolerance and clamp extremes plus a long output hold");
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/pldl_pkg.sv
hw/rtl/pldl_ram.sv
hw/rtl/pldl_div.sv
hw/rtl/phase_locked_delay_line.sv
tb/testbench.sv
